FILE: sv/mh_pkg.sv
// shared constants, types and angle table for the magnetometer heading block
package mh_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_IDX_W   = 5;
    localparam int SAMPLE_W      = 13;
    localparam int CORR_W        = SAMPLE_W + 1;
    localparam int XY_W          = 32;
    localparam int XY_SCALE      = 16;
    localparam int Z_W           = 28;
    localparam int Z_FRAC        = 12;
    localparam int ANG_W         = Z_W - Z_FRAC;
    localparam int H_W           = 18;
    localparam int DECL_W        = 15;
    localparam int HEAD_W        = 15;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 16;

    localparam logic signed [Z_W-1:0] HALF_TURN_ACC = 28'sd47185920;
    localparam logic signed [Z_W-1:0] ROUND_HALF    = 28'sd2048;
    localparam logic signed [H_W-1:0] FULL_TURN     = 18'sd23040;

    localparam logic signed [SAMPLE_W-1:0] X_BIAS_RST = 13'sd0;
    localparam logic signed [SAMPLE_W-1:0] Y_BIAS_RST = -13'sd116;
    localparam logic signed [DECL_W-1:0]   DECL_RST   = 15'sd156;
    localparam logic [HEAD_W-1:0]          ZERO_RST   = 15'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_BIAS       = 2'd0,
        REG_Y_BIAS       = 2'd1,
        REG_DECLINATION  = 2'd2,
        REG_ZERO_HEADING = 2'd3
    } mh_reg_idx_t;

    // vector in flight through the rotation chain
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } mh_vec_t;

    // atan(2^-i) in units of 1/(64*4096) degree
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STAGE_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 28'sd11796480;
            5'd1:    val = 28'sd6963869;
            5'd2:    val = 28'sd3679517;
            5'd3:    val = 28'sd1867780;
            5'd4:    val = 28'sd937515;
            5'd5:    val = 28'sd469214;
            5'd6:    val = 28'sd234664;
            5'd7:    val = 28'sd117339;
            5'd8:    val = 28'sd58671;
            5'd9:    val = 28'sd29335;
            5'd10:   val = 28'sd14668;
            5'd11:   val = 28'sd7334;
            5'd12:   val = 28'sd3667;
            5'd13:   val = 28'sd1833;
            5'd14:   val = 28'sd917;
            5'd15:   val = 28'sd458;
            5'd16:   val = 28'sd229;
            5'd17:   val = 28'sd115;
            5'd18:   val = 28'sd57;
            5'd19:   val = 28'sd29;
            5'd20:   val = 28'sd14;
            5'd21:   val = 28'sd7;
            5'd22:   val = 28'sd4;
            5'd23:   val = 28'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/mh_prep.sv
// input stage: hard-iron correction, half-plane fold and scaling into the rotation chain
module mh_prep
    import mh_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] x_raw,
    input  logic signed [SAMPLE_W-1:0] y_raw,
    input  logic signed [SAMPLE_W-1:0] x_bias,
    input  logic signed [SAMPLE_W-1:0] y_bias,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mh_vec_t                    out_vec
);

    logic                     valid_reg;
    mh_vec_t                  vec_reg;
    mh_vec_t                  vec_next;
    logic signed [CORR_W-1:0] xc;
    logic signed [CORR_W-1:0] yc;
    logic signed [XY_W-1:0]   xw;
    logic signed [XY_W-1:0]   yw;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb begin
        xc = CORR_W'(x_raw) - CORR_W'(x_bias);
        yc = CORR_W'(y_raw) - CORR_W'(y_bias);
        xw = XY_W'(xc);
        yw = XY_W'(yc);
        vec_next.zero = (xc == '0) && (yc == '0);
        vec_next.z    = '0;
        // left half-plane: turn by 180 degrees first
        if (xc < 0) begin
            vec_next.z = (yc >= 0) ? HALF_TURN_ACC : -HALF_TURN_ACC;
            xw = -xw;
            yw = -yw;
        end
        vec_next.x = xw <<< XY_SCALE;
        vec_next.y = yw <<< XY_SCALE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

endmodule

FILE: sv/mh_cell.sv
// one vectoring rotation of the cordic chain
module mh_cell
    import mh_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [STAGE_IDX_W-1:0] stage_idx,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mh_vec_t                in_vec,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mh_vec_t                out_vec
);

    logic                   valid_reg;
    mh_vec_t                vec_reg;
    mh_vec_t                vec_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   y_pos;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb begin
        xs    = in_vec.x >>> stage_idx;
        ys    = in_vec.y >>> stage_idx;
        y_pos = !in_vec.y[XY_W-1] && (in_vec.y != '0);
        vec_next.zero = in_vec.zero;
        if (y_pos) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + atan_entry(stage_idx);
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - atan_entry(stage_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

endmodule

FILE: sv/mh_wrap.sv
// rounds the angle, adds declination and folds into one turn
module mh_wrap
    import mh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  mh_vec_t                  in_vec,
    input  logic signed [DECL_W-1:0] declination,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [H_W-1:0]    out_h
);

    logic                    valid_reg;
    logic signed [H_W-1:0]   h_reg;
    logic signed [H_W-1:0]   h_next;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [ANG_W-1:0] ang;
    logic signed [H_W-1:0]   h_sum;
    logic signed [H_W-1:0]   h_up;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_h     = h_reg;

    always_comb begin
        z_rnd  = in_vec.z + ROUND_HALF;
        ang    = in_vec.zero ? '0 : z_rnd[Z_W-1:Z_FRAC];
        h_sum  = H_W'(ang) + H_W'(declination);
        h_up   = (h_sum < 0) ? h_sum + FULL_TURN : h_sum;
        // exactly one full turn is kept as is
        h_next = (h_up > FULL_TURN) ? h_up - FULL_TURN : h_up;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            h_reg <= h_next;
        end
    end

endmodule

FILE: sv/mh_out.sv
// output stage: zero-heading reference, final wrap and clamp
module mh_out
    import mh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [H_W-1:0] in_h,
    input  logic [HEAD_W-1:0]     zero_heading,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [HEAD_W-1:0]     out_heading
);

    logic                  valid_reg;
    logic [HEAD_W-1:0]     heading_reg;
    logic [HEAD_W-1:0]     heading_next;
    logic signed [H_W-1:0] d;
    logic signed [H_W-1:0] d_up;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_heading = heading_reg;

    always_comb begin
        d    = in_h - $signed(H_W'(zero_heading));
        d_up = (d < 0) ? d + FULL_TURN : d;
        if (d_up < 0) begin
            heading_next = '0;
        end else if (d_up > FULL_TURN) begin
            heading_next = HEAD_W'(FULL_TURN);
        end else begin
            heading_next = d_up[HEAD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            heading_reg <= heading_next;
        end
    end

endmodule

FILE: sv/magnetometer_heading.sv
// top level: compass heading from one magnetometer x/y word
// Takes one x/y word per cycle while s_tready is high and returns one
// heading word per input, in 1/64 degree from 0 to 23040 (360 degrees),
// through a bias correction stage, one rotation cell per cordic stage
// (16), a rounding plus declination stage and a zero-heading stage. Each
// stage holds its own word and moves on whenever the next stage is free, so
// gaps close up under output back-pressure and s_tready only drops once all
// stages are full. Registers are written through cfg_wr_en/cfg_addr/
// cfg_wr_data (0 x_bias, 1 y_bias, 2 declination, 3 zero_heading) and should
// only change while no word is in flight.
module magnetometer_heading
    import mh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,     // x_raw[12:0], y_raw[25:13], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,     // heading[14:0], zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic signed [SAMPLE_W-1:0] x_bias_reg;
    logic signed [SAMPLE_W-1:0] y_bias_reg;
    logic signed [DECL_W-1:0]   declination_reg;
    logic [HEAD_W-1:0]          zero_heading_reg;

    mh_vec_t                chain_vec   [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] chain_valid;
    logic [CORDIC_STAGES:0] chain_ready;

    logic                  wrap_valid;
    logic                  wrap_ready;
    logic signed [H_W-1:0] wrap_h;
    logic [HEAD_W-1:0]     heading;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_bias_reg       <= X_BIAS_RST;
            y_bias_reg       <= Y_BIAS_RST;
            declination_reg  <= DECL_RST;
            zero_heading_reg <= ZERO_RST;
        end else if (cfg_wr_en) begin
            case (mh_reg_idx_t'(cfg_addr))
                REG_X_BIAS:       x_bias_reg       <= cfg_wr_data[SAMPLE_W-1:0];
                REG_Y_BIAS:       y_bias_reg       <= cfg_wr_data[SAMPLE_W-1:0];
                REG_DECLINATION:  declination_reg  <= cfg_wr_data[DECL_W-1:0];
                REG_ZERO_HEADING: zero_heading_reg <= cfg_wr_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    mh_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_raw     (s_tdata[SAMPLE_W-1:0]),
        .y_raw     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .x_bias    (x_bias_reg),
        .y_bias    (y_bias_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        mh_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STAGE_IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_vec    (chain_vec[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_vec   (chain_vec[g+1])
        );
    end

    mh_wrap u_wrap (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (chain_valid[CORDIC_STAGES]),
        .in_ready    (chain_ready[CORDIC_STAGES]),
        .in_vec      (chain_vec[CORDIC_STAGES]),
        .declination (declination_reg),
        .out_valid   (wrap_valid),
        .out_ready   (wrap_ready),
        .out_h       (wrap_h)
    );

    mh_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (wrap_valid),
        .in_ready     (wrap_ready),
        .in_h         (wrap_h),
        .zero_heading (zero_heading_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_heading  (heading)
    );

    assign m_tdata = M_TDATA_W'(heading);

    // heading never leaves one turn
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (heading <= HEAD_W'(FULL_TURN)))
        else $error("heading above full turn");

    // input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && wrap_valid && (&chain_valid)))
        else $error("input stalled with free stage");

    // register reset values
    a_cfg_reset: assert property (@(posedge aclk)
        !aresetn |=> (y_bias_reg == Y_BIAS_RST && declination_reg == DECL_RST
                      && x_bias_reg == X_BIAS_RST && zero_heading_reg == ZERO_RST))
        else $error("register reset value wrong");

endmodule
